/* sv/sdeb_pkg.sv */
// shared types and constants for the direction energy histogram
// no dependencies
package sdeb_pkg;

	localparam int CordicSteps = 14;
	localparam logic [15:0] HalfTurn = 16'd32768;
	localparam logic [15:0] QuarterTurn = 16'd16384;

	typedef enum logic [1:0] {
		CFG_INCREMENT = 2'd0,
		CFG_CEILING = 2'd1,
		CFG_DECAY_STEP = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic signed [15:0] x_pos;
		logic signed [15:0] y_pos;
		logic [15:0] source_energy;
		logic frame_start;
	} in_item_t;

	typedef struct packed {
		logic [5:0] hit_bin;
		logic [8:0] peak_angle;
		logic [7:0] peak_level;
	} out_item_t;

	// atan(2^-i) in turn units
	function automatic logic [15:0] turn_atan(input logic [3:0] i);
		logic [15:0] r;
		case (i)
			4'd0: r = 16'd8192;
			4'd1: r = 16'd4836;
			4'd2: r = 16'd2555;
			4'd3: r = 16'd1297;
			4'd4: r = 16'd651;
			4'd5: r = 16'd326;
			4'd6: r = 16'd163;
			4'd7: r = 16'd81;
			4'd8: r = 16'd41;
			4'd9: r = 16'd20;
			4'd10: r = 16'd10;
			4'd11: r = 16'd5;
			4'd12: r = 16'd3;
			4'd13: r = 16'd1;
			default: r = 16'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/sound_direction_energy_bins.sv */
// Direction energy histogram. Each transaction decays all bins (twice on frame
// start), adds floor(increment*energy/65536) into the bin of the source angle
// (clamped at ceiling) and returns the hit bin and the strongest bin. The bins
// live in a synchronous RAM with one read and one write port; every pass
// walks it one entry a cycle. Each accepted item runs one or two decay sweeps,
// a read-modify-write of the hit bin once the cordic is done, a peak sweep,
// then the result; a new item is accepted only after that result is taken.
// After reset a clearing pass runs before the first item is accepted.
// depends on sdeb_pkg, sdeb_cordic
module sound_direction_energy_bins #(
	parameter int BIN_COUNT = 36
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sdeb_pkg::in_item_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output sdeb_pkg::out_item_t out_data,
	input  logic cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	localparam int AW = $clog2(BIN_COUNT);
	// per-bin angle step as quotient and remainder of 360 / BIN_COUNT
	localparam int AngStep = 360 / BIN_COUNT;
	localparam int AngRem = 360 % BIN_COUNT;

	typedef enum logic [7:0] {
		ST_CLEAR = 8'b0000_0001,
		ST_IDLE = 8'b0000_0010,
		ST_DECAY = 8'b0000_0100,
		ST_HITRD = 8'b0000_1000,
		ST_HITWR = 8'b0001_0000,
		ST_PEAK = 8'b0010_0000,
		ST_OUT = 8'b0100_0000,
		ST_WAIT = 8'b1000_0000
	} state_t;

	state_t state_q;
	logic [7:0] increment_q, ceiling_q, decay_step_q;
	sdeb_pkg::in_item_t item_q;
	logic [AW:0] rd_cnt_q;   // read address counter
	logic [AW:0] wr_cnt_q;   // write-back address, one behind
	logic rd_valid_q;
	logic second_q, cordic_done_q;
	logic [AW-1:0] hit_q;
	logic [7:0] add_q, best_q;
	logic [8:0] ang_q, best_ang_q;
	logic [AW:0] rem_q, rem_sum;

	// bin memory
	logic [7:0] mem [BIN_COUNT];
	logic mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [7:0] mem_wdata, mem_rdata;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		mem_rdata <= mem[mem_raddr];
	end

	// cordic
	logic cordic_start, cordic_done;
	logic [15:0] turns;
	sdeb_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cordic_start),
		.x_in(in_data.x_pos), .y_in(in_data.y_pos),
		.done(cordic_done), .turns(turns)
	);

	logic [31:0] bin_prod;
	logic [23:0] add_prod;
	logic [7:0] decayed;
	logic [8:0] level;
	assign bin_prod = 32'(turns) * 32'(BIN_COUNT);
	assign add_prod = increment_q * item_q.source_energy;
	assign decayed = (mem_rdata > decay_step_q) ? mem_rdata - decay_step_q : 8'd0;
	assign level = ({1'b0, mem_rdata} + {1'b0, add_q} > {1'b0, ceiling_q})
		? {1'b0, ceiling_q} : {1'b0, mem_rdata} + {1'b0, add_q};
	assign rem_sum = rem_q + (AW+1)'(AngRem);

	assign in_stall = (state_q != ST_IDLE);
	assign cordic_start = (state_q == ST_IDLE) && in_valid;
	assign out_valid = (state_q == ST_WAIT);

	// memory access steering
	always_comb begin
		mem_we = 1'b0;
		mem_waddr = wr_cnt_q[AW-1:0];
		mem_wdata = decayed;
		mem_raddr = rd_cnt_q[AW-1:0];
		case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
				mem_waddr = rd_cnt_q[AW-1:0];
				mem_wdata = 8'd0;
			end
			ST_DECAY: mem_we = rd_valid_q;
			ST_HITRD: mem_raddr = hit_q;
			ST_HITWR: begin
				mem_raddr = hit_q;
				mem_we = rd_valid_q;
				mem_waddr = hit_q;
				mem_wdata = level[7:0];
			end
			default: ;
		endcase
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			increment_q <= 8'd20;
			ceiling_q <= 8'd200;
			decay_step_q <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				sdeb_pkg::CFG_INCREMENT: increment_q <= cfg_data;
				sdeb_pkg::CFG_CEILING: ceiling_q <= cfg_data;
				sdeb_pkg::CFG_DECAY_STEP: decay_step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			rd_valid_q <= 1'b0;
			second_q <= 1'b0;
			cordic_done_q <= 1'b0;
		end else begin
			if (cordic_done) begin
				cordic_done_q <= 1'b1;
				hit_q <= AW'(bin_prod[31:16]);
			end
			case (state_q)
				ST_CLEAR: begin
					if (rd_cnt_q == (AW+1)'(BIN_COUNT - 1)) begin
						rd_cnt_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
				end
				ST_IDLE: if (in_valid) begin
					item_q <= in_data;
					second_q <= !in_data.frame_start;
					cordic_done_q <= 1'b0;
					rd_cnt_q <= '0;
					rd_valid_q <= 1'b0;
					state_q <= ST_DECAY;
				end
				ST_DECAY: begin
					add_q <= add_prod[23:16];
					wr_cnt_q <= rd_cnt_q;
					rd_valid_q <= (rd_cnt_q < (AW+1)'(BIN_COUNT));
					if (rd_cnt_q < (AW+1)'(BIN_COUNT)) rd_cnt_q <= rd_cnt_q + 1'b1;
					else if (!rd_valid_q) begin
						rd_cnt_q <= '0;
						if (second_q) state_q <= ST_HITRD;
						else second_q <= 1'b1;
					end
				end
				ST_HITRD: begin
					rd_valid_q <= 1'b0;
					if (cordic_done_q) begin
						state_q <= ST_HITWR;
					end
				end
				ST_HITWR: begin
					if (rd_valid_q) begin
						state_q <= ST_PEAK;
						rd_cnt_q <= '0;
						rd_valid_q <= 1'b0;
						best_q <= 8'd0;
						best_ang_q <= '0;
						ang_q <= '0;
						rem_q <= '0;
					end else begin
						rd_valid_q <= 1'b1;
					end
				end
				ST_PEAK: begin
					wr_cnt_q <= rd_cnt_q;
					rd_valid_q <= (rd_cnt_q < (AW+1)'(BIN_COUNT));
					if (rd_cnt_q < (AW+1)'(BIN_COUNT)) rd_cnt_q <= rd_cnt_q + 1'b1;
					if (rd_valid_q) begin
						if (mem_rdata > best_q) begin
							best_q <= mem_rdata;
							best_ang_q <= ang_q;
						end
						// angle of the next bin, stepped without a divider
						if (rem_sum >= (AW+1)'(BIN_COUNT)) begin
							rem_q <= rem_sum - (AW+1)'(BIN_COUNT);
							ang_q <= ang_q + 9'(AngStep + 1);
						end else begin
							rem_q <= rem_sum;
							ang_q <= ang_q + 9'(AngStep);
						end
					end
					if (rd_cnt_q == (AW+1)'(BIN_COUNT) && !rd_valid_q) state_q <= ST_OUT;
				end
				ST_OUT: begin
					out_data.hit_bin <= 6'(hit_q);
					out_data.peak_angle <= best_ang_q;
					out_data.peak_level <= best_q;
					state_q <= ST_WAIT;
				end
				ST_WAIT: if (!out_stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// a result leaves only after the peak sweep
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == ST_OUT)
		else $error("result without peak sweep");
	// no memory write while idle or holding a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_WAIT) |-> !mem_we)
		else $error("memory write while idle");
	// stalled result holds its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed");
	// hit bin in range
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_HITWR |-> {1'b0, hit_q} < (AW+1)'(BIN_COUNT))
		else $error("hit bin out of range");
`endif

endmodule

/* sv/sdeb_cordic.sv */
// iterative cordic vectoring unit: direction of (x, y) in turns
// depends on sdeb_pkg
module sdeb_cordic (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	output logic done,
	output logic [15:0] turns
);

	// scaled inputs grow by the cordic gain, so keep headroom above 19 bits
	logic signed [20:0] x_q, y_q;
	logic [15:0] z_q;
	logic [3:0] i_q;
	logic busy_q;
	logic signed [20:0] dx, dy;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign turns = z_q;

	// one rotation per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (y_in == 16'sd0) begin
					z_q <= (x_in < 0) ? sdeb_pkg::HalfTurn : 16'd0;
					done <= 1'b1;
				end else if (x_in == 16'sd0) begin
					z_q <= (y_in > 0) ? sdeb_pkg::QuarterTurn
						: sdeb_pkg::HalfTurn + sdeb_pkg::QuarterTurn;
					done <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					if (x_in < 0) begin
						x_q <= -({{5{x_in[15]}}, x_in} <<< 2);
						y_q <= -({{5{y_in[15]}}, y_in} <<< 2);
						z_q <= sdeb_pkg::HalfTurn;
					end else begin
						x_q <= {{5{x_in[15]}}, x_in} <<< 2;
						y_q <= {{5{y_in[15]}}, y_in} <<< 2;
						z_q <= 16'd0;
					end
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + dx;
					y_q <= y_q - dy;
					z_q <= z_q + sdeb_pkg::turn_atan(i_q);
				end else begin
					x_q <= x_q - dx;
					y_q <= y_q + dy;
					z_q <= z_q - sdeb_pkg::turn_atan(i_q);
				end
				i_q <= i_q + 4'd1;
				if (i_q == 4'(sdeb_pkg::CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

endmodule

/* tb/sv/tb_top.sv */
// self-checking testbench for sound_direction_energy_bins
// depends on sdeb_pkg and the sound_direction_energy_bins rtl
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BinCount = 36;
	localparam int CycleLimit = 1500000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sdeb_pkg::in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sdeb_pkg::out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data = '0;

	sound_direction_energy_bins #(.BIN_COUNT(BinCount)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// predictor state
	logic [7:0] bins_model [BinCount];
	logic [7:0] gain_reg, ceil_reg, decay_reg;
	sdeb_pkg::out_item_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	// directed rows: item and, where obvious, the result
	typedef struct {
		sdeb_pkg::in_item_t item;
		bit fixed;
		sdeb_pkg::out_item_t result;
	} row_t;

	row_t rows[$];

	function automatic void add_row(input row_t r);
		rows.insert(rows.size(), r);
	endfunction

	task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	function automatic logic signed [31:0] asr(input logic signed [31:0] v, input int s);
		return v >>> s;
	endfunction

	// direction in turns, 16 fraction bits
	function automatic logic [15:0] angle_of(input logic signed [15:0] x,
			input logic signed [15:0] y);
		logic signed [31:0] xs, ys, dx, dy, z;
		if (y == 0) return (x < 0) ? sdeb_pkg::HalfTurn : 16'd0;
		if (x == 0) return (y > 0) ? sdeb_pkg::QuarterTurn : 16'd49152;
		xs = 32'(x) * 4;
		ys = 32'(y) * 4;
		z = 0;
		if (xs < 0) begin
			xs = -xs;
			ys = -ys;
			z = 32768;
		end
		for (int i = 0; i < sdeb_pkg::CordicSteps; i++) begin
			dx = asr(ys, i);
			dy = asr(xs, i);
			if (ys >= 0) begin
				xs += dx;
				ys -= dy;
				z += 32'(sdeb_pkg::turn_atan(4'(i)));
			end else begin
				xs -= dx;
				ys += dy;
				z -= 32'(sdeb_pkg::turn_atan(4'(i)));
			end
		end
		return z[15:0];
	endfunction

	function automatic void decay_bins();
		for (int i = 0; i < BinCount; i++)
			bins_model[i] = (bins_model[i] > decay_reg) ? bins_model[i] - decay_reg : 8'd0;
	endfunction

	function automatic sdeb_pkg::out_item_t histogram_step(input sdeb_pkg::in_item_t it);
		sdeb_pkg::out_item_t r;
		int bin, lvl, best, idx;
		decay_bins();
		if (it.frame_start) decay_bins();
		bin = (int'(angle_of(it.x_pos, it.y_pos)) * BinCount) >> 16;
		if (bin >= BinCount) bin = BinCount - 1;
		lvl = int'(bins_model[bin]) + ((int'(gain_reg) * int'(it.source_energy)) >> 16);
		if (lvl > ceil_reg) lvl = ceil_reg;
		bins_model[bin] = 8'(lvl);
		best = bins_model[0];
		idx = 0;
		for (int i = 1; i < BinCount; i++)
			if (bins_model[i] > best) begin
				best = bins_model[i];
				idx = i;
			end
		r.hit_bin = 6'(bin);
		r.peak_angle = 9'(idx * 360 / BinCount);
		r.peak_level = 8'(best);
		return r;
	endfunction

	// register write, only while idle
	task automatic write_reg(input sdeb_pkg::cfg_idx_t idx, input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			sdeb_pkg::CFG_INCREMENT: gain_reg = v;
			sdeb_pkg::CFG_CEILING: ceil_reg = v;
			sdeb_pkg::CFG_DECAY_STEP: decay_reg = v;
			default: ;
		endcase
	endtask

	// send one transaction; valid stays high across back-to-back items
	task automatic send(input sdeb_pkg::in_item_t it, input bit fixed,
			input sdeb_pkg::out_item_t want);
		sdeb_pkg::out_item_t p;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
		p = histogram_step(it);
		if (fixed && p != want) report("directed table", 16'(p), 16'(want));
		expected_q.insert(expected_q.size(), p);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (130) @(negedge clk);
	endtask

	function automatic sdeb_pkg::in_item_t rand_item();
		sdeb_pkg::in_item_t it;
		it.x_pos = 16'($urandom);
		it.y_pos = 16'($urandom);
		case ($urandom_range(7))
			0: it.x_pos = 0;
			1: it.y_pos = 0;
			2: it.source_energy = 16'hFFFF;
			default: ;
		endcase
		it.source_energy = ($urandom_range(9) == 0) ? 16'($urandom_range(1)) * 16'hFFFF
			: 16'($urandom);
		it.frame_start = ($urandom_range(3) == 0);
		return it;
	endfunction

	// receiver: stall at random and check each result
	always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

	always @(posedge clk) begin
		sdeb_pkg::out_item_t w;
		cycles++;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("unexpected result transaction");
				errors++;
			end else begin
				w = expected_q.pop_front();
				if (out_data.hit_bin != w.hit_bin) report("hit_bin", 16'(out_data.hit_bin), 16'(w.hit_bin));
				if (out_data.peak_angle != w.peak_angle)
					report("peak_angle", 16'(out_data.peak_angle), 16'(w.peak_angle));
				if (out_data.peak_level != w.peak_level)
					report("peak_level", 16'(out_data.peak_level), 16'(w.peak_level));
			end
		end
		if (cycles > CycleLimit) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic row_t mk(input int x, input int y, input int e, input bit fs,
			input bit fixed, input int hb, input int pa, input int pl);
		row_t r;
		r.item = '{x_pos: 16'(x), y_pos: 16'(y), source_energy: 16'(e), frame_start: fs};
		r.fixed = fixed;
		r.result = '{hit_bin: 6'(hb), peak_angle: 9'(pa), peak_level: 8'(pl)};
		return r;
	endfunction

	initial begin
		int phase_items;
		foreach (bins_model[i]) bins_model[i] = 0;
		gain_reg = 20;
		ceil_reg = 200;
		decay_reg = 1;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: axes, zero vector, extremes, frame start, diagonals
		add_row(mk(0, 0, 0, 0, 1, 0, 0, 0));
		add_row(mk(0, 0, 65535, 0, 1, 0, 0, 19));
		add_row(mk(32767, 0, 65535, 1, 1, 0, 0, 36));
		add_row(mk(0, 32767, 65535, 0, 1, 9, 0, 35));
		add_row(mk(-32768, 0, 65535, 0, 1, 18, 0, 34));
		add_row(mk(0, -32768, 65535, 1, 1, 27, 0, 32));
		add_row(mk(23170, 23170, 65535, 0, 0, 0, 0, 0));
		add_row(mk(-23170, 23170, 40000, 0, 0, 0, 0, 0));
		add_row(mk(-23170, -23170, 1, 1, 0, 0, 0, 0));
		add_row(mk(23170, -23170, 65535, 0, 0, 0, 0, 0));
		add_row(mk(32767, -1, 65535, 0, 0, 0, 0, 0));
		add_row(mk(-32768, -1, 65535, 0, 0, 0, 0, 0));
		add_row(mk(-32768, 1, 65535, 0, 0, 0, 0, 0));
		add_row(mk(-1, -32768, 65535, 1, 0, 0, 0, 0));
		add_row(mk(-32768, -32768, 65535, 0, 0, 0, 0, 0));
		add_row(mk(32767, 32767, 65535, 0, 0, 0, 0, 0));
		foreach (rows[i]) send(rows[i].item, rows[i].fixed, rows[i].result);
		drain();

		// register extremes: max gain, zero ceiling, low ceiling, max decay
		write_reg(sdeb_pkg::CFG_INCREMENT, 8'd255);
		write_reg(sdeb_pkg::CFG_CEILING, 8'd255);
		write_reg(sdeb_pkg::CFG_DECAY_STEP, 8'd0);
		for (int i = 0; i < 6; i++) send(mk(1000, 0, 65535, 0, 0, 0, 0, 0).item, 0, '0);
		drain();
		write_reg(sdeb_pkg::CFG_CEILING, 8'd0);
		send(mk(1000, 0, 65535, 0, 0, 0, 0, 0).item, 0, '0);
		drain();
		write_reg(sdeb_pkg::CFG_CEILING, 8'd1);
		write_reg(sdeb_pkg::CFG_INCREMENT, 8'd0);
		send(mk(0, 1000, 65535, 1, 0, 0, 0, 0).item, 0, '0);
		drain();
		write_reg(sdeb_pkg::CFG_DECAY_STEP, 8'd255);
		write_reg(sdeb_pkg::CFG_INCREMENT, 8'd255);
		send(mk(0, 1000, 65535, 1, 0, 0, 0, 0).item, 0, '0);
		drain();

		// random phases under three idling patterns and several settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin send_idle_pct = 37; recv_idle_pct = 51; end
				1: begin send_idle_pct = 51; recv_idle_pct = 37; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			write_reg(sdeb_pkg::CFG_INCREMENT, (ph == 5) ? 8'd255 : 8'($urandom));
			write_reg(sdeb_pkg::CFG_CEILING, (ph == 4) ? 8'd255 : 8'($urandom_range(255, 1)));
			write_reg(sdeb_pkg::CFG_DECAY_STEP, (ph == 3) ? 8'd0 : 8'($urandom_range(6)));
			phase_items = 165;
			for (int n = 0; n < phase_items; n++) send(rand_item(), 0, '0);
			drain();
		end
		recv_idle_pct = 0;
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end
endmodule

/* sim.f */
sv/sdeb_pkg.sv
sv/sdeb_cordic.sv
sv/sound_direction_energy_bins.sv
tb/sv/tb_top.sv
